/* design/ultrasonic_echo_ranger_assert.svh */
// assertion macros for the echo ranger
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("echo ranger assertion failed");
// next-cycle implication, disabled in reset
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("echo ranger assertion failed");
`else
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/uer_pkg.sv */
package uer_pkg;

    // register indexes on the config port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO_TICKS = 2'd3;
    localparam int unsigned CFG_DATA_W = 13;

    // field widths
    localparam int unsigned TRIG_W  = 10;
    localparam int unsigned TOUT_W  = 12;
    localparam int unsigned MAXE_W  = 13;
    localparam int unsigned MINE_W  = 8;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned DIST_W  = 14;

    // reset values of the registers
    localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS  = 10'd100;
    localparam logic [TOUT_W-1:0] RST_START_TIMEOUT  = 12'd210;
    localparam logic [MAXE_W-1:0] RST_MAX_ECHO_TICKS = 13'd3501;
    localparam logic [MINE_W-1:0] RST_MIN_ECHO_TICKS = 8'd7;

    // count*100/58 = count*50/29, done as count*ceil(50*2^20/29) >> 20
    localparam int unsigned DIST_SHIFT = 20;
    localparam int unsigned DIST_MUL_W = 21;
    localparam int unsigned DIST_PROD_W = CNT_W + DIST_MUL_W;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL = 21'd1807890;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ECHO   = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TOO_CLOSE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_ECHO = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_ticks;
        logic [TOUT_W-1:0] start_timeout;
        logic [MAXE_W-1:0] max_echo_ticks;
        logic [MINE_W-1:0] min_echo_ticks;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        t_status           status;
        logic              done;
        logic              trigger;
    } t_result;

endpackage

/* design/uer_cfg.sv */
module uer_cfg
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register file, written one register per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks  <= RST_TRIGGER_TICKS;
            r_cfg.start_timeout  <= RST_START_TIMEOUT;
            r_cfg.max_echo_ticks <= RST_MAX_ECHO_TICKS;
            r_cfg.min_echo_ticks <= RST_MIN_ECHO_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRIGGER_TICKS:  r_cfg.trigger_ticks  <= i_cfg_wdata[TRIG_W-1:0];
                REG_START_TIMEOUT:  r_cfg.start_timeout  <= i_cfg_wdata[TOUT_W-1:0];
                REG_MAX_ECHO_TICKS: r_cfg.max_echo_ticks <= i_cfg_wdata[MAXE_W-1:0];
                REG_MIN_ECHO_TICKS: r_cfg.min_echo_ticks <= i_cfg_wdata[MINE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/uer_dist.sv */
module uer_dist
    import uer_pkg::*;
(
    input  logic [CNT_W-1:0]  i_count,
    output logic [DIST_W-1:0] o_dist
);

    logic [DIST_PROD_W-1:0] prod;

    // reciprocal multiply, exact for every 13-bit count
    assign prod   = DIST_PROD_W'(i_count) * DIST_PROD_W'(DIST_MUL);
    assign o_dist = prod[DIST_SHIFT +: DIST_W];

endmodule

/* design/uer_seq.sv */
module uer_seq
    import uer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_start,
    input  logic    i_echo,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  trig_cnt, wait_cnt, high_cnt;
    logic [DIST_W-1:0] dist_cm;
    logic              trig_end, do_wait, do_echo, dist_sel;
    t_result           res;

    uer_dist u_dist (
        .i_count (r_cnt),
        .o_dist  (dist_cm)
    );

    assign trig_cnt = r_cnt + CNT_W'(1);
    assign trig_end = trig_cnt >= CNT_W'(i_cfg.trigger_ticks);
    // wait and echo counts restart at zero when the phase is entered this tick
    assign wait_cnt = (r_phase == PH_WAIT) ? r_cnt : '0;
    assign high_cnt = (r_phase == PH_ECHO) ? r_cnt : '0;

    // next state and result for one word
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        do_wait    = 1'b0;
        do_echo    = 1'b0;
        dist_sel   = 1'b0;
        res.done   = 1'b0;
        res.status = ST_OK;
        if (i_start) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_TRIG;
                n_cnt   = '0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_TRIG: begin
                    if (trig_end) begin
                        do_wait = 1'b1;
                    end else begin
                        n_cnt = trig_cnt;
                    end
                end
                PH_WAIT: do_wait = 1'b1;
                PH_ECHO: do_echo = 1'b1;
                default: ;
            endcase
            // waiting for the echo to rise
            if (do_wait) begin
                if (i_echo) begin
                    do_echo = 1'b1;
                end else if (wait_cnt >= CNT_W'(i_cfg.start_timeout)) begin
                    res.done   = 1'b1;
                    res.status = ST_NO_ECHO;
                end else begin
                    n_phase = PH_WAIT;
                    n_cnt   = wait_cnt + CNT_W'(1);
                end
            end
            // counting the echo pulse
            if (do_echo) begin
                if (i_echo) begin
                    if (high_cnt >= i_cfg.max_echo_ticks) begin
                        res.done   = 1'b1;
                        res.status = ST_TOO_LONG;
                    end else begin
                        n_phase = PH_ECHO;
                        n_cnt   = high_cnt + CNT_W'(1);
                    end
                end else begin
                    res.done = 1'b1;
                    if (high_cnt <= CNT_W'(i_cfg.min_echo_ticks)) begin
                        res.status = ST_TOO_CLOSE;
                    end else begin
                        dist_sel = 1'b1;
                    end
                end
            end
            if (res.done) begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        end
        res.trigger  = (n_phase == PH_TRIG);
        res.distance = dist_sel ? dist_cm : '0;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    assign o_res = res;

endmodule

/* design/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: each input word is either a 10 us tick (tuser 0) carrying the
// sampled echo pin in tdata bit 0, or a start command (tuser 1), and each gives exactly one
// output word with the trigger pin level, a done flag, a status (ok, no echo, echo too long,
// too close) and the distance in cm (count*100/58, nonzero only on a successful end). A word
// is accepted every cycle except while the output register holds a result against a low
// m_axis_tready; its result is registered, and the rate is set by the sequencer update and one
// constant multiply for the distance. Config registers (trigger ticks, start timeout, max and
// min echo ticks) must be written by the user only while idle; the block does not enforce this.
`include "ultrasonic_echo_ranger_assert.svh"
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [0] echo_level, [7:1] zero
    input  logic                  s_axis_tuser,  // [0] command
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata   // [0] trigger_level, [1] done_res,
                                                 // [3:2] status, [17:4] distance_cm, [23:18] zero
);

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_valid;
    logic    accept;

    uer_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    uer_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_start  (s_axis_tuser),
        .i_echo   (s_axis_tdata[0]),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    // take a word whenever the result register is free or being drained
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'b0, r_res};

    // checks
    `UER_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, r_valid && !m_axis_tready, !s_axis_tready)
    `UER_ASSERT_NOW(a_no_trigger_on_done, i_clk, i_rst_n, r_valid, !(r_res.trigger && r_res.done))
    `UER_ASSERT_NOW(a_dist_only_when_ok, i_clk, i_rst_n, r_valid && (!r_res.done || r_res.status != ST_OK), r_res.distance == '0)
    `UER_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, r_valid)

endmodule

/* dv/echo_ranger_checker.sv */
`timescale 1ns / 100ps
module echo_ranger_checker
    import uer_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    input  logic [7:0]            i_in_tdata,   // [0] echo_level, [7:1] zero
    input  logic                  i_in_tuser,   // [0] command
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    input  logic [23:0]           i_out_tdata,  // [0] trigger_level, [1] done_res,
                                                // [3:2] status, [17:4] distance_cm
    output int                    o_mismatches,
    output int                    o_pending,
    output logic                  o_busy
);

    // shadow of the ranger: registers, sequencer phase and tick counter
    t_cfg             ranger_cfg;
    t_phase           seq_phase = PH_IDLE;
    logic [CNT_W-1:0] tick_count = '0;
    t_result          expected_readings[$];
    t_result          predicted;
    t_result          oldest;
    int               mismatches = 0;
    int               pending = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;
    assign o_busy       = (seq_phase != PH_IDLE);

    // one word through the sequencer: a start command or a 10 us tick
    task automatic step_ranger(input logic start, input logic echo, output t_result res);
        logic        finished;
        t_status     verdict;
        int unsigned range_cm;
        finished = 1'b0;
        verdict  = ST_OK;
        range_cm = 0;
        if (start) begin
            // start only counts when nothing is running
            if (seq_phase == PH_IDLE) begin
                seq_phase  = PH_TRIG;
                tick_count = '0;
            end
        end else begin
            // trigger pulse; the tick that ends it is also the first echo sample
            if (seq_phase == PH_TRIG) begin
                tick_count = tick_count + 1'b1;
                if (tick_count >= ranger_cfg.trigger_ticks) begin
                    seq_phase  = PH_WAIT;
                    tick_count = '0;
                end
            end
            // waiting for the echo to rise
            if (seq_phase == PH_WAIT) begin
                if (echo) begin
                    seq_phase  = PH_ECHO;
                    tick_count = '0;
                end else if (tick_count >= ranger_cfg.start_timeout) begin
                    finished = 1'b1;
                    verdict  = ST_NO_ECHO;
                end else begin
                    tick_count = tick_count + 1'b1;
                end
            end
            // measuring the echo width, rising tick included
            if (seq_phase == PH_ECHO && !finished) begin
                if (echo) begin
                    if (tick_count >= ranger_cfg.max_echo_ticks) begin
                        finished = 1'b1;
                        verdict  = ST_TOO_LONG;
                    end else begin
                        tick_count = tick_count + 1'b1;
                    end
                end else begin
                    finished = 1'b1;
                    if (tick_count <= ranger_cfg.min_echo_ticks)
                        verdict = ST_TOO_CLOSE;
                    else
                        range_cm = (32'(tick_count) * 32'd100) / 32'd58;
                end
            end
            if (finished) begin
                seq_phase  = PH_IDLE;
                tick_count = '0;
            end
        end
        res.trigger  = (seq_phase == PH_TRIG);
        res.done     = finished;
        res.status   = verdict;
        res.distance = range_cm[DIST_W-1:0];
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // watch both streams and the register port at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ranger_cfg.trigger_ticks  = RST_TRIGGER_TICKS;
            ranger_cfg.start_timeout  = RST_START_TIMEOUT;
            ranger_cfg.max_echo_ticks = RST_MAX_ECHO_TICKS;
            ranger_cfg.min_echo_ticks = RST_MIN_ECHO_TICKS;
            seq_phase  = PH_IDLE;
            tick_count = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TRIGGER_TICKS:  ranger_cfg.trigger_ticks  = i_cfg_wdata[TRIG_W-1:0];
                    REG_START_TIMEOUT:  ranger_cfg.start_timeout  = i_cfg_wdata[TOUT_W-1:0];
                    REG_MAX_ECHO_TICKS: ranger_cfg.max_echo_ticks = i_cfg_wdata[MAXE_W-1:0];
                    REG_MIN_ECHO_TICKS: ranger_cfg.min_echo_ticks = i_cfg_wdata[MINE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_tvalid && i_in_tready) begin
                step_ranger(i_in_tuser, i_in_tdata[0], predicted);
                expected_readings.push_back(predicted);
            end
            if (i_out_tvalid && i_out_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("result word with no reading pending: tdata %h", i_out_tdata);
                    mismatches++;
                end else begin
                    oldest = expected_readings.pop_front();
                    compare_field("trigger_level", oldest.trigger, i_out_tdata[0]);
                    compare_field("done_res", oldest.done, i_out_tdata[1]);
                    compare_field("status", oldest.status, i_out_tdata[3:2]);
                    compare_field("distance_cm", oldest.distance, i_out_tdata[17:4]);
                end
            end
        end
        pending = expected_readings.size();
    end

endmodule

/* dv/tb_ultrasonic_echo_ranger.sv */
`timescale 1ns / 100ps
module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned PHASE_WORDS   = 200;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [0] echo_level, [7:1] zero
    logic                  s_axis_tuser;   // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // [0] trigger_level, [1] done_res,
                                           // [3:2] status, [17:4] distance_cm, [23:18] zero

    int          mismatch_count;
    int          words_pending;
    logic        ranger_busy;
    logic        steady = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned phase_words = 0;

    // register values as last written, used to shape the echo sequences
    int unsigned cur_trig = RST_TRIGGER_TICKS;
    int unsigned cur_tout = RST_START_TIMEOUT;
    int unsigned cur_maxe = RST_MAX_ECHO_TICKS;
    int unsigned cur_mine = RST_MIN_ECHO_TICKS;

    ultrasonic_echo_ranger uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    echo_ranger_checker u_ranger_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_mismatches (mismatch_count),
        .o_pending    (words_pending),
        .o_busy       (ranger_busy)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 28);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ultrasonic_echo_ranger regression: fail");
            $finish;
        end
    end

    // one word on the input stream, with random idle cycles in front
    task automatic send_word(input logic start, input logic echo);
        while (!steady && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= {7'd0, echo};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        phase_words++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TRIGGER_TICKS:  cur_trig = value % (1 << TRIG_W);
            REG_START_TIMEOUT:  cur_tout = value % (1 << TOUT_W);
            REG_MAX_ECHO_TICKS: cur_maxe = value % (1 << MAXE_W);
            REG_MIN_ECHO_TICKS: cur_mine = value % (1 << MINE_W);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned trig, input int unsigned tout,
                              input int unsigned maxe, input int unsigned mine);
        write_reg(REG_TRIGGER_TICKS, trig);
        write_reg(REG_START_TIMEOUT, tout);
        write_reg(REG_MAX_ECHO_TICKS, maxe);
        write_reg(REG_MIN_ECHO_TICKS, mine);
    endtask

    // hold off the sender until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // low echo ticks end whatever measurement is still running
    task automatic finish_run();
        while (ranger_busy) send_word(1'b0, 1'b0);
    endtask

    task automatic to_idle();
        finish_run();
        settle();
    endtask

    // start, trigger ticks, then lows, highs and a falling edge
    task automatic measure(input int unsigned lows, input int unsigned highs, input bit noisy);
        int unsigned trig_len;
        int unsigned k;
        logic        echo;
        finish_run();
        trig_len = (cur_trig == 0) ? 1 : cur_trig;
        send_word(1'b1, $urandom_range(1) == 1);
        for (k = 1; k < trig_len; k++) begin
            send_word(1'b0, $urandom_range(1) == 1);
            if (noisy && $urandom_range(9) == 0)
                send_word(1'b1, $urandom_range(1) == 1);
        end
        for (k = 0; k <= lows + highs; k++) begin
            echo = (k >= lows) && (k < lows + highs);
            if (noisy && $urandom_range(9) == 0)
                echo = ~echo;
            send_word(1'b0, echo);
            if (noisy && $urandom_range(19) == 0)
                send_word(1'b1, $urandom_range(1) == 1);
        end
    endtask

    // pick echo timing around the timeout and width limits
    task automatic random_measurement();
        int unsigned lows;
        int unsigned highs;
        case ($urandom_range(3))
            0: lows = 0;
            1: lows = cur_tout;
            2: lows = cur_tout + 1;
            default: lows = $urandom_range(0, (cur_tout < 12) ? cur_tout : 12);
        endcase
        case ($urandom_range(7))
            0: highs = cur_maxe;
            1: highs = cur_maxe + 1;
            2: highs = cur_mine;
            3: highs = cur_mine + 1;
            default: highs = $urandom_range(1, cur_mine + 40);
        endcase
        if (highs == 0)
            highs = 1;
        measure(lows, highs, $urandom_range(99) < 20);
        // stray words between measurements
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1))
                send_word($urandom_range(1) == 1, $urandom_range(1) == 1);
        if ($urandom_range(9) == 0)
            settle();
    endtask

    initial begin
        int unsigned ph;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register reset values: full trigger length, then a short echo
        measure(4, 12, 1'b0);
        to_idle();

        // zero-length trigger, zero timeout and zero echo limit
        set_config(0, 0, 0, 0);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
        to_idle();

        // echo rising on the trigger's last tick, too close, no echo, good range
        set_config(2, 3, 9, 2);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        repeat (6) send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b0);
        repeat (4) send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        to_idle();

        // random phases, each under its own register setting
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config($urandom_range(4, 8), $urandom_range(20, 40),
                              $urandom_range(50, 80), $urandom_range(8, 20));
                5: set_config($urandom_range(1, 3), 4, 300, 255);
                default: set_config($urandom_range(0, 6), $urandom_range(0, 12),
                                    $urandom_range(0, 40), $urandom_range(0, 30));
            endcase
            steady      <= (ph == 2);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
                random_measurement();
            steady <= 1'b0;
            to_idle();
        end

        // upper register bits set: trigger truncates to one tick, widest limits
        set_config(32'h1C01, 32'h1FFF, 32'h1FFF, 32'h1FFF);
        measure(3, cur_mine + 45, 1'b0);
        to_idle();

        if (mismatch_count == 0)
            $display("ultrasonic_echo_ranger regression: pass");
        else
            $display("ultrasonic_echo_ranger regression: fail");
        $finish;
    end

endmodule
